FILE: rtl/osrb_pkg.sv
// Shared types and constants for the overwriting sample ring buffer.
package osrb_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD
  } state_t;

  localparam logic [0:0]  REG_CAPACITY = 1'b0;
  localparam logic [15:0] CAP_RESET    = 16'd32768;

  typedef struct packed {
    logic wr;
    logic clr;
    logic start;
    logic fetch;
    logic load;
    logic prefetch;
    logic load_empty;
  } osrb_cmd_t;

  typedef struct packed {
    logic burst_zero;
    logic rem_one;
  } osrb_sts_t;

endpackage

FILE: rtl/osrb_ram.sv
// Generic single-port-write, registered-read RAM.
module osrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/osrb_ctrl.sv
// Controller state machine for the ring buffer: request handshake and burst sequencing.
module osrb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  osrb_pkg::osrb_sts_t   sts,
  output osrb_pkg::osrb_cmd_t   cmd
);

  osrb_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign in_stall = (state_r != osrb_pkg::ST_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      osrb_pkg::ST_IDLE: begin
        if (accept && (in_command == osrb_pkg::CMD_READ) && !sts.burst_zero) begin
          state_nxt = osrb_pkg::ST_FETCH;
        end
      end
      osrb_pkg::ST_FETCH: begin
        state_nxt = osrb_pkg::ST_LOAD;
      end
      osrb_pkg::ST_LOAD: begin
        if (out_free && sts.rem_one) begin
          state_nxt = osrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = osrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      osrb_pkg::ST_IDLE: begin
        cmd.wr         = accept && (in_command == osrb_pkg::CMD_WRITE);
        cmd.clr        = accept && (in_command == osrb_pkg::CMD_CLEAR);
        cmd.start      = accept && (in_command == osrb_pkg::CMD_READ) && !sts.burst_zero;
        cmd.load_empty = accept && (in_command == osrb_pkg::CMD_READ) && sts.burst_zero;
      end
      osrb_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      osrb_pkg::ST_LOAD: begin
        cmd.load     = out_free;
        cmd.prefetch = out_free && !sts.rem_one;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load || cmd.load_empty) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= osrb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/osrb_dp.sv
// Datapath for the ring buffer: pointers, fill count, capacity register, sample RAM, output register.
module osrb_dp #(
  parameter int DEPTH     = 32768,
  parameter int MAX_BURST = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  osrb_pkg::osrb_cmd_t  cmd,
  output osrb_pkg::osrb_sts_t  sts,
  input  logic                 cap_we,
  input  logic [15:0]          cap_wdata,
  output logic [15:0]          cap,
  input  logic signed [15:0]   in_sample,
  input  logic [6:0]           in_max_read,
  output logic signed [15:0]   out_read_sample,
  output logic                 out_sample_valid,
  output logic                 out_last,
  output logic [15:0]          out_fill_level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int ADV_W = ((PTR_W > 16) ? PTR_W : 16) + 1;
  localparam int BW    = $clog2(MAX_BURST + 1);
  localparam logic [15:0] DEPTH_CAP = (DEPTH > 65535) ? 16'hFFFF : 16'(DEPTH);
  localparam logic [6:0]  MB        = 7'(MAX_BURST);

  logic [15:0]      cap_r;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [15:0]      fill_r, fill_nxt;
  logic [BW-1:0]    rem_r, rem_nxt;

  logic [15:0]      cap_eff;
  logic [ADV_W-1:0] wp_inc, rp_inc;
  logic [PTR_W-1:0] wp_adv, rp_adv;
  logic [6:0]       lim, burst_n;
  logic [15:0]      ram_rdata;
  logic [PTR_W-1:0] ram_raddr;

  logic signed [15:0] out_sample_r;
  logic               out_sv_r;
  logic               out_last_r;
  logic [15:0]        out_fill_r;

  always_comb begin
    cap_eff = cap_r;
    if (cap_r == 16'd0) begin
      cap_eff = 16'd1;
    end else if (cap_r > DEPTH_CAP) begin
      cap_eff = DEPTH_CAP;
    end
  end

  assign wp_inc = ADV_W'(wp_r) + ADV_W'(1);
  assign rp_inc = ADV_W'(rp_r) + ADV_W'(1);
  assign wp_adv = (wp_inc >= ADV_W'(cap_eff)) ? '0 : wp_inc[PTR_W-1:0];
  assign rp_adv = (rp_inc >= ADV_W'(cap_eff)) ? '0 : rp_inc[PTR_W-1:0];

  assign lim     = (in_max_read > MB) ? MB : in_max_read;
  assign burst_n = ({9'd0, lim} > fill_r) ? fill_r[6:0] : lim;

  assign sts.burst_zero = (burst_n == 7'd0);
  assign sts.rem_one    = (rem_r == BW'(1));

  assign ram_raddr = cmd.prefetch ? rp_adv : rp_r;

  osrb_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wp_r),
    .wdata (in_sample),
    .re    (cmd.fetch || cmd.prefetch),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    fill_nxt = fill_r;
    rem_nxt  = rem_r;
    priority if (cmd.clr) begin
      wp_nxt   = '0;
      rp_nxt   = '0;
      fill_nxt = '0;
    end else if (cmd.wr) begin
      wp_nxt = wp_adv;
      if (fill_r < cap_eff) begin
        fill_nxt = fill_r + 16'd1;
      end else begin
        rp_nxt = rp_adv;
      end
    end else if (cmd.start) begin
      rem_nxt = BW'(burst_n);
    end else if (cmd.load) begin
      rp_nxt   = rp_adv;
      fill_nxt = fill_r - 16'd1;
      rem_nxt  = rem_r - BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= osrb_pkg::CAP_RESET;
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
      rem_r  <= '0;
    end else begin
      if (cap_we) begin
        cap_r <= cap_wdata;
      end
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_sample_r <= ram_rdata;
      out_sv_r     <= 1'b1;
      out_last_r   <= sts.rem_one;
      out_fill_r   <= fill_r - 16'd1;
    end else if (cmd.load_empty) begin
      out_sample_r <= '0;
      out_sv_r     <= 1'b0;
      out_last_r   <= 1'b1;
      out_fill_r   <= fill_r;
    end
  end

  assign cap              = cap_r;
  assign out_read_sample  = out_sample_r;
  assign out_sample_valid = out_sv_r;
  assign out_last         = out_last_r;
  assign out_fill_level   = out_fill_r;

endmodule

FILE: rtl/overwriting_sample_ring_buffer.sv
// Top level of the overwriting sample ring buffer: controller, datapath and register port.
// Writes and clears act in the cycle they are taken; writes sustain one per cycle while in_stall is low.
// A read request goes through FETCH for the first RAM read, then delivers one result per cycle
// while the output is not stalled; each result is moved from the RAM into the output register in LOAD.
// The next request is taken once the final result of a burst has left the output register.
// Synchronous active-low reset clears the pointers, fill count and output valid, and sets
// capacity to 32768; sample RAM contents are not cleared.
module overwriting_sample_ring_buffer #(
  parameter int DEPTH     = 32768,
  parameter int MAX_BURST = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_sample,
  input  logic [6:0]         in_max_read,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_read_sample,
  output logic               out_sample_valid,
  output logic               out_last,
  output logic [15:0]        out_fill_level,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  osrb_pkg::osrb_cmd_t cmd;
  osrb_pkg::osrb_sts_t sts;
  logic                cap_we;
  logic [15:0]         cap;

  assign pready = 1'b1;
  assign cap_we = psel && penable && pwrite && pready && (paddr[2] == osrb_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == osrb_pkg::REG_CAPACITY) ? {16'd0, cap} : 32'd0;

  osrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  osrb_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cap_we           (cap_we),
    .cap_wdata        (pwdata[15:0]),
    .cap              (cap),
    .in_sample        (in_sample),
    .in_max_read      (in_max_read),
    .out_read_sample  (out_read_sample),
    .out_sample_valid (out_sample_valid),
    .out_last         (out_last),
    .out_fill_level   (out_fill_level)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sample_valid) |-> (out_last && (out_read_sample == 16'sd0)))
    else $error("empty read result must be a zero sample marked last");

  a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> (in_stall && out_valid))
    else $error("a burst must continue after a non-final result");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load || cmd.load_empty) |-> !(out_valid && out_stall))
    else $error("output register overwritten while a result is stalled");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr, cmd.clr, cmd.start, cmd.load, cmd.load_empty}))
    else $error("more than one datapath action in a cycle");

endmodule
